@@ hw/rtl/rha_pkg.sv @@
// ---------------------------------------------------------------------------
// rha_pkg
// shared types and constants for the range histogram accumulator
// ---------------------------------------------------------------------------
package rha_pkg;

    // register indexes
    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BUCKETS    = 2'd2;
    localparam logic [1:0] REG_NORM       = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic bin_start;   // latch sample and start bucket division
        logic bin_step;    // one division step
        logic bin_fetch;   // read count of the selected bucket
        logic bin_commit;  // update count memory
        logic rd_start;    // begin readout, clear bucket pointer
        logic rd_fetch;    // issue memory read for current bucket
        logic norm_start;  // start q16 ratio
        logic norm_step;   // one ratio step
        logic out_load;    // load output register
        logic rd_next;     // advance bucket pointer
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_range;    // latched sample is in range
        logic div_done;    // bucket division finished
        logic norm_done;   // ratio finished
        logic rd_last;     // current bucket is the last in use
        logic norm_mode;   // normalized output selected
        logic is_last;     // latched vector_last
    } t_status;

endpackage

@@ hw/rtl/rha_datapath.sv @@
// ---------------------------------------------------------------------------
// rha_datapath
// binning divider, count memory, running total, q16 ratio unit, output reg
// ---------------------------------------------------------------------------
module rha_datapath
    import rha_pkg::*;
#(
    parameter int MAX_BUCKETS = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_vlast,
    input  logic [SAMPLE_BITS-1:0] i_range_low,
    input  logic [SAMPLE_BITS-1:0] i_range_high,
    input  logic [6:0]             i_bucket_count,
    input  logic                   i_norm_mode,
    output logic [5:0]             o_bucket_index,
    output logic [31:0]            o_bucket_value,
    output logic [31:0]            o_total_count,
    output logic                   o_range_miss,
    output logic                   o_last_bucket
);

    localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW = $clog2(MAX_BUCKETS + 1);
    localparam int SW = SAMPLE_BITS + 1;         // span / offset width
    localparam int PW = SW + NW;                 // n * off width
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // buckets in use
    logic [NW-1:0] w_n;
    always_comb begin
        if (i_bucket_count == 7'd0) begin
            w_n = NW'(1);
        end else if ({25'd0, i_bucket_count} > MAX_BUCKETS) begin
            w_n = NW'(MAX_BUCKETS);
        end else begin
            w_n = NW'(i_bucket_count);
        end
    end

    // range test and offsets
    logic signed [SW-1:0] w_s, w_lo, w_hi;
    assign w_s  = SW'($signed(i_sample));
    assign w_lo = SW'($signed(i_range_low));
    assign w_hi = SW'($signed(i_range_high));
    logic w_in;
    assign w_in = (w_s >= w_lo) && (w_s < w_hi);

    // restoring divider, one quotient bit a cycle
    logic [PW-1:0]          r_num;
    logic [SW-1:0]          r_den;
    logic [PW-1:0]          r_rem;
    logic [PW-1:0]          r_quo;
    logic [$clog2(PW+1)-1:0] r_dcnt;
    logic                   r_in, r_vlast, r_miss;
    logic [PW-1:0]          w_rsh;
    assign w_rsh = {r_rem[PW-2:0], r_num[PW-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_start) begin
            r_num  <= PW'(w_n) * PW'(unsigned'(w_s - w_lo));
            r_den  <= unsigned'(w_hi - w_lo);
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= '0;
            r_in   <= w_in;
            r_vlast <= i_vlast;
        end else if (i_cmd.bin_step) begin
            r_num  <= {r_num[PW-2:0], 1'b0};
            r_dcnt <= r_dcnt + 1'b1;
            if (w_rsh >= PW'(r_den)) begin
                r_rem <= w_rsh - PW'(r_den);
                r_quo <= {r_quo[PW-2:0], 1'b1};
            end else begin
                r_rem <= w_rsh;
                r_quo <= {r_quo[PW-2:0], 1'b0};
            end
        end
    end

    // bucket memory, cleared by valid bits
    logic [COUNT_BITS-1:0] r_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_vld;
    logic [COUNT_BITS-1:0] r_rdata;
    logic [COUNT_BITS-1:0] r_total;
    logic [AW-1:0]         r_ptr;
    logic [AW-1:0]         w_bin;
    logic [AW-1:0]         w_raddr;

    assign w_bin = (r_quo >= PW'(w_n)) ? AW'(w_n - 1'b1) : AW'(r_quo);
    assign w_raddr = i_cmd.rd_fetch ? r_ptr : w_bin;

    // registered read of the selected bucket, commit writes the incremented count
    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_fetch || i_cmd.rd_fetch) begin
            r_rdata <= r_vld[w_raddr] ? r_mem[w_raddr] : '0;
        end
        if (i_cmd.bin_commit && r_in) begin
            r_mem[w_bin] <= (r_rdata == CMAX) ? r_rdata : r_rdata + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_total <= '0;
            r_miss  <= 1'b0;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.bin_commit) begin
                if (r_in) begin
                    r_vld[w_bin] <= 1'b1;
                    if (r_total != CMAX) r_total <= r_total + 1'b1;
                end else begin
                    r_miss <= 1'b1;
                end
            end
            if (i_cmd.rd_start) r_ptr <= '0;
            if (i_cmd.rd_next) begin
                r_ptr <= r_ptr + 1'b1;
                if (o_status.rd_last) r_miss <= 1'b0;
            end
        end
    end

    // q16 ratio unit, one bit a cycle
    logic [COUNT_BITS-1:0] r_nr, r_nden;
    logic [16:0]           r_nq;
    logic [4:0]            r_ncnt;
    logic                  r_nfull;
    logic [COUNT_BITS-1:0] w_diff;
    assign w_diff = r_nden - r_nr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_start) begin
            r_nr    <= r_rdata;
            r_nden  <= r_total;
            r_nq    <= '0;
            r_ncnt  <= '0;
            r_nfull <= (r_rdata >= r_total);
        end else if (i_cmd.norm_step) begin
            r_ncnt <= r_ncnt + 1'b1;
            if (r_nr >= w_diff) begin
                r_nr <= r_nr - w_diff;
                r_nq <= {r_nq[15:0], 1'b1};
            end else begin
                r_nr <= r_nr + r_nr;
                r_nq <= {r_nq[15:0], 1'b0};
            end
        end
    end

    // output register
    logic [31:0] w_val;
    always_comb begin
        if (!i_norm_mode) begin
            w_val = 32'(r_rdata);
        end else if (r_total == '0) begin
            w_val = '0;
        end else if (r_nfull) begin
            w_val = 32'd65536;
        end else begin
            w_val = 32'(r_nq);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_bucket_index <= 6'(r_ptr);
            o_bucket_value <= w_val;
            o_total_count  <= 32'(r_total);
            o_range_miss   <= r_miss;
            o_last_bucket  <= o_status.rd_last;
        end
    end

    assign o_status.in_range  = r_in;
    assign o_status.div_done  = (r_dcnt == ($clog2(PW+1))'(PW - 1));
    assign o_status.norm_done = (r_ncnt == 5'd15);
    assign o_status.rd_last   = (NW'(r_ptr) + 1'b1 == w_n);
    assign o_status.norm_mode = i_norm_mode;
    assign o_status.is_last   = r_vlast;

endmodule

@@ hw/rtl/rha_ctrl.sv @@
// ---------------------------------------------------------------------------
// rha_ctrl
// sequencer for binning and readout
// ---------------------------------------------------------------------------
module rha_ctrl
    import rha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_fire,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_DIV   = 9'b0_0000_0010,
        S_BRD   = 9'b0_0000_0100,
        S_COMM  = 9'b0_0000_1000,
        S_FETCH = 9'b0_0001_0000,
        S_WAIT  = 9'b0_0010_0000,
        S_NORM  = 9'b0_0100_0000,
        S_LOAD  = 9'b0_1000_0000,
        S_OUT   = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.bin_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.bin_step = 1'b1;
                if (i_status.div_done) n_state = S_BRD;
            end
            // read the count of the bucket just found
            S_BRD: begin
                o_cmd.bin_fetch = 1'b1;
                n_state = S_COMM;
            end
            S_COMM: begin
                o_cmd.bin_commit = 1'b1;
                if (i_status.is_last) begin
                    o_cmd.rd_start = 1'b1;
                    n_state = S_FETCH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                o_cmd.rd_fetch = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.norm_start = 1'b1;
                n_state = i_status.norm_mode ? S_NORM : S_LOAD;
            end
            S_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (i_status.norm_done) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.rd_next = 1'b1;
                    n_state = i_status.rd_last ? S_IDLE : S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/range_histogram_accumulator.sv @@
// ---------------------------------------------------------------------------
// range_histogram_accumulator
// fixed-range histogram with raw or q1.16 normalized readout
// ---------------------------------------------------------------------------
// a sample passes through these steps:
// accept, serial bucket divider, bucket read, count update
// readout per bucket: fetch, wait, serial q16 ratio unit if normalized, load, output
// input is held off while a readout runs
// synchronous active-low reset clears counts (valid bits), total, miss flag
module range_histogram_accumulator
    import rha_pkg::*;
#(
    parameter int MAX_BUCKETS = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample
    input  logic        s_axis_tlast,   // vector_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // bucket_index, bucket_value, total_count, pad
    output logic        m_axis_tlast,   // last_bucket
    output logic        m_axis_tuser,   // range_miss
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_lo, r_hi;
    logic [6:0]  r_bc;
    logic        r_nm;
    logic        w_wr;
    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= 16'd32767;
            r_bc <= 7'd64;
            r_nm <= 1'b0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_RANGE_LOW:  r_lo <= pwdata[15:0];
                REG_RANGE_HIGH: r_hi <= pwdata[15:0];
                REG_BUCKETS:    r_bc <= pwdata[6:0];
                REG_NORM:       r_nm <= pwdata[0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_RANGE_LOW:  prdata = {16'd0, r_lo};
            REG_RANGE_HIGH: prdata = {16'd0, r_hi};
            REG_BUCKETS:    prdata = {25'd0, r_bc};
            REG_NORM:       prdata = {31'd0, r_nm};
            default:        prdata = '0;
        endcase
    end

    t_cmd    w_cmd;
    t_status w_st;
    logic    w_fire;
    assign w_fire = s_axis_tvalid && s_axis_tready;

    rha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_out_ready(m_axis_tready), .i_status(w_st), .o_cmd(w_cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    logic [5:0]  w_idx;
    logic [31:0] w_val, w_tot;

    rha_datapath #(
        .MAX_BUCKETS(MAX_BUCKETS), .SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_st),
        .i_sample(SAMPLE_BITS'(s_axis_tdata)), .i_vlast(s_axis_tlast),
        .i_range_low(SAMPLE_BITS'(r_lo)), .i_range_high(SAMPLE_BITS'(r_hi)),
        .i_bucket_count(r_bc), .i_norm_mode(r_nm),
        .o_bucket_index(w_idx), .o_bucket_value(w_val), .o_total_count(w_tot),
        .o_range_miss(m_axis_tuser), .o_last_bucket(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_tot, w_val, w_idx};

    // no input accepted during readout
    a_no_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input taken during readout");
    // output stays valid until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

endmodule
